// File: rtl/rvcs_pkg.sv
// ----------------------------------------------------------------------------
// rvcs_pkg - shared types and constants for the voxel corruption selector
// Twister constants, register map, and controller/datapath command types.
// ----------------------------------------------------------------------------
package rvcs_pkg;

   localparam int unsigned MT_N = 624;
   localparam int unsigned MT_M = 397;

   typedef logic [31:0] word_type;
   typedef logic [32:0] thr_type;
   typedef logic [9:0]  tw_idx_type;
   typedef logic [2:0]  csr_idx_type;

   localparam tw_idx_type IDX_LAST = tw_idx_type'(MT_N - 1);

   localparam word_type MT_UPPER     = 32'h8000_0000;
   localparam word_type MT_LOWER     = 32'h7FFF_FFFF;
   localparam word_type MT_MATRIX    = 32'h9908_B0DF;
   localparam word_type MT_INIT_MULT = 32'd1812433253;
   localparam word_type SEED_RESET   = 32'd5489;

   localparam csr_idx_type CSR_SEED               = 3'd0;
   localparam csr_idx_type CSR_BOUNDARY_ENABLE    = 3'd1;
   localparam csr_idx_type CSR_BOUNDARY_THRESHOLD = 3'd2;
   localparam csr_idx_type CSR_POISSON_ENABLE     = 3'd3;
   localparam csr_idx_type CSR_POISSON_THRESHOLD  = 3'd4;

   typedef struct packed {
      logic accept;     // capture the incoming word
      logic seed_init;  // write seed to entry 0, start seeding sweep
      logic seed_mul;   // init multiply on previous entry
      logic seed_add;   // add index, write entry
      logic draw_rd;    // read next and far entries
      logic draw_ev;    // regenerate entry, temper, compare
      logic load_rsp;   // move decision into output register
   } dp_cmd_type;

   typedef struct packed {
      logic need_seed;
      logic any_draw;
      logic more_draws;
      logic seed_last;
   } dp_status_type;

   function automatic word_type mt_temper(input word_type w);
      word_type y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic word_type mt_regen(input word_type cur, input word_type nxt,
                                         input word_type far);
      word_type y;
      word_type v;
      y = (cur & MT_UPPER) | (nxt & MT_LOWER);
      v = far ^ (y >> 1);
      if (y[0]) begin
         v = v ^ MT_MATRIX;
      end
      return v;
   endfunction

endpackage

// File: rtl/random_voxel_corruption_selector_core.sv
// Takes one voxel word at a time and returns one corrupt flag for it, drawn
// from an MT19937 generator whose 624-word state sits in an on-chip memory
// with one write and two read ports. Each draw regenerates its state entry
// in place: a memory read, then regenerate, temper, compare and write back.
// A word makes 0, 1 or 2 draws between acceptance and its result, and the
// input reopens in the cycle after the result is loaded. A reseed (start of
// volume, or the first word after reset) comes first and fills each state
// entry from the previous one through the init multiply. The next word is
// accepted while a finished result still waits in the output register.

// ----------------------------------------------------------------------------
// random_voxel_corruption_selector_core - top level
// Joins the sequencing controller and the twister datapath.
// ----------------------------------------------------------------------------
module random_voxel_corruption_selector_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [15:0]      req_distance,
   input  logic                    req_start_of_volume,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_corrupt,
   input  logic                    csr_wr_en,
   input  rvcs_pkg::csr_idx_type   csr_index,
   input  rvcs_pkg::thr_type       csr_wdata
);
   import rvcs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rvcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rvcs_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_distance        (req_distance),
      .req_start_of_volume (req_start_of_volume),
      .rsp_corrupt         (rsp_corrupt)
   );

endmodule

// File: rtl/rvcs_datapath.sv
// ----------------------------------------------------------------------------
// rvcs_datapath - twister state memory, seeding and draw datapath
// Holds the config registers, the 624-word state memory, the seeding
// multiplier and the regenerate/temper/compare path.
// ----------------------------------------------------------------------------
module rvcs_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  rvcs_pkg::dp_cmd_type      cmd,
   output rvcs_pkg::dp_status_type   status,
   input  logic                      csr_wr_en,
   input  rvcs_pkg::csr_idx_type     csr_index,
   input  rvcs_pkg::thr_type         csr_wdata,
   input  logic signed [15:0]        req_distance,
   input  logic                      req_start_of_volume,
   output logic                      rsp_corrupt
);
   import rvcs_pkg::*;

   word_type   seed_ff, seed_in;
   logic       b_en_ff, b_en_in;
   thr_type    b_thr_ff, b_thr_in;
   logic       p_en_ff, p_en_in;
   thr_type    p_thr_ff, p_thr_in;

   logic       seeded_ff, seeded_in;
   logic       need_seed_ff, need_seed_in;
   logic       do_b_ff, do_b_in;
   logic       do_p_ff, do_p_in;
   logic       mutate_ff, mutate_in;
   tw_idx_type pos_ff, pos_in;

   word_type   cur_ff, cur_in;
   word_type   prev_ff, prev_in;
   word_type   prod_ff, prod_in;
   word_type   rd_next_ff;
   word_type   rd_far_ff;
   logic       rsp_corrupt_ff, rsp_corrupt_in;

   word_type   mem [MT_N];

   tw_idx_type pos_next;
   tw_idx_type addr_far;
   logic [10:0] far_sum;
   word_type   seed_val;
   word_type   new_word;
   word_type   tempered;
   thr_type    thr_sel;
   logic       hit;
   logic       dist_le0;
   logic       wr_en;
   tw_idx_type wr_addr;
   word_type   wr_data;

   assign pos_next = (pos_ff == IDX_LAST) ? '0 : pos_ff + 10'd1;
   assign far_sum  = {1'b0, pos_ff} + 11'(MT_M);
   assign addr_far = (far_sum >= 11'(MT_N)) ? tw_idx_type'(far_sum - 11'(MT_N))
                                            : tw_idx_type'(far_sum);

   assign seed_val = prod_ff + word_type'(pos_ff);
   assign new_word = mt_regen(cur_ff, rd_next_ff, rd_far_ff);
   assign tempered = mt_temper(new_word);
   assign thr_sel  = do_b_ff ? b_thr_ff : p_thr_ff;
   assign hit      = {1'b0, tempered} < thr_sel;
   assign dist_le0 = req_distance[15] | (req_distance == 16'sd0);

   assign status.need_seed  = need_seed_ff;
   assign status.any_draw   = do_b_ff | do_p_ff;
   assign status.more_draws = do_b_ff & do_p_ff;
   assign status.seed_last  = (pos_ff == IDX_LAST);

   assign rsp_corrupt = rsp_corrupt_ff;

   // config writes
   always_comb begin
      seed_in  = seed_ff;
      b_en_in  = b_en_ff;
      b_thr_in = b_thr_ff;
      p_en_in  = p_en_ff;
      p_thr_in = p_thr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SEED:               seed_in  = csr_wdata[31:0];
            CSR_BOUNDARY_ENABLE:    b_en_in  = csr_wdata[0];
            CSR_BOUNDARY_THRESHOLD: b_thr_in = csr_wdata;
            CSR_POISSON_ENABLE:     p_en_in  = csr_wdata[0];
            CSR_POISSON_THRESHOLD:  p_thr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      seeded_in      = seeded_ff;
      need_seed_in   = need_seed_ff;
      do_b_in        = do_b_ff;
      do_p_in        = do_p_ff;
      mutate_in      = mutate_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prod_in        = prod_ff;
      rsp_corrupt_in = rsp_corrupt_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = new_word;

      if (cmd.accept) begin
         need_seed_in = req_start_of_volume | ~seeded_ff;
         do_b_in      = b_en_ff & dist_le0;
         do_p_in      = p_en_ff;
         mutate_in    = 1'b0;
      end
      if (cmd.seed_init) begin
         need_seed_in = 1'b0;
         seeded_in    = 1'b1;
         cur_in       = seed_ff;
         prev_in      = seed_ff;
         pos_in       = 10'd1;
         wr_en        = 1'b1;
         wr_addr      = '0;
         wr_data      = seed_ff;
      end
      if (cmd.seed_mul) begin
         prod_in = MT_INIT_MULT * (prev_ff ^ (prev_ff >> 30));
      end
      if (cmd.seed_add) begin
         prev_in = seed_val;
         pos_in  = pos_next;   // wraps to 0 after the last entry
         wr_en   = 1'b1;
         wr_data = seed_val;
      end
      if (cmd.draw_ev) begin
         // in-place regeneration: entry k is rebuilt just before it is used
         cur_in    = rd_next_ff;
         pos_in    = pos_next;
         wr_en     = 1'b1;
         mutate_in = mutate_ff | hit;
         if (do_b_ff) begin
            do_b_in = 1'b0;
         end else begin
            do_p_in = 1'b0;
         end
      end
      if (cmd.load_rsp) begin
         rsp_corrupt_in = mutate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RESET;
         b_en_ff      <= 1'b0;
         b_thr_ff     <= '0;
         p_en_ff      <= 1'b0;
         p_thr_ff     <= '0;
         seeded_ff    <= 1'b0;
         need_seed_ff <= 1'b0;
         do_b_ff      <= 1'b0;
         do_p_ff      <= 1'b0;
         mutate_ff    <= 1'b0;
         pos_ff       <= '0;
      end else begin
         seed_ff      <= seed_in;
         b_en_ff      <= b_en_in;
         b_thr_ff     <= b_thr_in;
         p_en_ff      <= p_en_in;
         p_thr_ff     <= p_thr_in;
         seeded_ff    <= seeded_in;
         need_seed_ff <= need_seed_in;
         do_b_ff      <= do_b_in;
         do_p_ff      <= do_p_in;
         mutate_ff    <= mutate_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      prod_ff        <= prod_in;
      rsp_corrupt_ff <= rsp_corrupt_in;
   end

   // state memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.draw_rd) begin
         rd_next_ff <= mem[pos_next];
         rd_far_ff  <= mem[addr_far];
      end
   end

endmodule

// File: rtl/rvcs_ctrl.sv
// ----------------------------------------------------------------------------
// rvcs_ctrl - sequencing controller for the voxel corruption selector
// Walks one word through reseed, boundary draw, Poisson draw and result.
// ----------------------------------------------------------------------------
module rvcs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rvcs_pkg::dp_cmd_type      cmd,
   input  rvcs_pkg::dp_status_type   status
);
   import rvcs_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PLAN     = 3'd1;
   localparam logic [2:0] ST_SEED_MUL = 3'd2;
   localparam logic [2:0] ST_SEED_ADD = 3'd3;
   localparam logic [2:0] ST_DRAW_RD  = 3'd4;
   localparam logic [2:0] ST_DRAW_EV  = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PLAN;
            end
         end
         ST_PLAN: begin
            priority if (status.need_seed) begin
               cmd.seed_init = 1'b1;
               state_in      = ST_SEED_MUL;
            end else if (status.any_draw) begin
               state_in = ST_DRAW_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEED_MUL: begin
            cmd.seed_mul = 1'b1;
            state_in     = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            cmd.seed_add = 1'b1;
            state_in     = status.seed_last ? ST_PLAN : ST_SEED_MUL;
         end
         ST_DRAW_RD: begin
            cmd.draw_rd = 1'b1;
            state_in    = ST_DRAW_EV;
         end
         ST_DRAW_EV: begin
            cmd.draw_ev = 1'b1;
            state_in    = status.more_draws ? ST_DRAW_RD : ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/rvcs_checker.sv
// ----------------------------------------------------------------------------
// rvcs_checker - port-level checks for the voxel corruption selector
// Tracks words in flight and checks one-at-a-time intake and the result handshake.
// ----------------------------------------------------------------------------
module rvcs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_corrupt
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pending_ff, pending_in;

   assign req_acc = req_valid & ~req_stall;
   assign rsp_acc = rsp_valid & ~rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc & ~rsp_acc) begin
         pending_in = pending_ff + 2'd1;
      end else if (~req_acc & rsp_acc) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_corrupt))
      else $error("result changed while stalled");

   // one word worked on at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("input reopened right after acceptance");

   // no result without an accepted word
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result with no word in flight");

   // at most one in the output register plus one in work
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many words in flight");

endmodule

bind random_voxel_corruption_selector_core rvcs_checker u_rvcs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_corrupt (rsp_corrupt)
);
